// File: design/zero_phase_biquad_cascade_assert.svh
// Assertion macros for the zero-phase biquad cascade checker.
// Included by the checker file only.
`ifndef ZERO_PHASE_BIQUAD_CASCADE_ASSERT_SVH
`define ZERO_PHASE_BIQUAD_CASCADE_ASSERT_SVH
// property checked on every rising clock edge outside reset
`define ZPBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition in one cycle implies condition in the next
`define ZPBC_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

// File: design/zpbc_pkg.sv
// Package for the zero-phase biquad cascade: sizes, coefficient table, FSM type.
// No dependencies.
`timescale 1ns / 1ps
package zpbc_pkg;
  localparam int BlockDepth = 64;
  localparam int Sections   = 4;
  localparam int MaxSect    = 8;
  localparam int AddrW      = $clog2(BlockDepth);
  localparam int CountW     = $clog2(BlockDepth + 1);
  localparam int SectW      = (Sections > 1) ? $clog2(Sections) : 1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_RDX, ST_M0, ST_T, ST_M1, ST_M3, ST_M2, ST_M4, ST_WB,
    ST_OUT_RD, ST_OUT
  } state_t;

  // coefficient c of section k, Q2.30: b0 b1 b2 a1 a2
  function automatic logic signed [31:0] coef(input logic [2:0] k, input logic [2:0] c);
    logic signed [31:0] r;
    r = 32'sd0;
    case (k)
      3'd0: case (c)
        3'd0: r = 32'sd3315729;
        3'd1: r = -32'sd6547781;
        3'd2: r = 32'sd3315729;
        3'd3: r = -32'sd2109204250;
        3'd4: r = 32'sd1036004543;
        default: r = 32'sd0;
      endcase
      3'd1: case (c)
        3'd0: r = 32'sd1073741824;
        3'd1: r = -32'sd2142569075;
        3'd2: r = 32'sd1073741824;
        3'd3: r = -32'sd2131482098;
        3'd4: r = 32'sd1058559159;
        default: r = 32'sd0;
      endcase
      3'd2: case (c)
        3'd0: r = 32'sd1073741824;
        3'd1: r = -32'sd2147482840;
        3'd2: r = 32'sd1073741824;
        3'd3: r = -32'sd2137162334;
        3'd4: r = 32'sd1063460230;
        default: r = 32'sd0;
      endcase
      3'd3: case (c)
        3'd0: r = 32'sd1073741824;
        3'd1: r = -32'sd2147479171;
        3'd2: r = 32'sd1073741824;
        3'd3: r = -32'sd2144708852;
        3'd4: r = 32'sd1070993696;
        default: r = 32'sd0;
      endcase
      default: r = (c == 3'd0) ? 32'sd1073741824 : 32'sd0;
    endcase
    return r;
  endfunction
endpackage

// File: design/zero_phase_biquad_cascade.sv
// Zero-phase biquad cascade: block store, shared multiplier, output stage.
// Depends on zpbc_pkg.
// Loading: one sample a cycle while in_stall is low. After the last request of a block
// the forward and reverse passes run through every section sample (one shared 32x32
// multiplier, 5 products and a store read/write per section sample), then n results:
// each is read in ST_OUT_RD, offered the cycle after, and held until it is taken.
// Reset (rst, synchronous) empties the block; the sample store is not cleared.
`timescale 1ns / 1ps
module zero_phase_biquad_cascade (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample_in,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample_out,
  output logic               last_out
);
  import zpbc_pkg::*;

  logic signed [31:0] store [BlockDepth];
  logic signed [39:0] dly   [2*Sections];

  state_t state, state_next;
  logic [CountW-1:0] fill, idx;
  logic [SectW-1:0]  sect;
  logic              back;

  logic signed [31:0] rd_data, x, y;
  logic signed [63:0] prod;
  logic signed [39:0] t;
  logic signed [43:0] n1;
  logic signed [31:0] mul_a;
  logic [2:0]         csel;

  logic               we;
  logic [AddrW-1:0]   waddr, raddr;
  logic signed [31:0] wdata;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != ST_LOAD);

  always_ff @(posedge clk) begin
    if (we) store[waddr] <= wdata;
    rd_data <= store[raddr];
  end

  function automatic logic signed [39:0] sat40(input logic signed [43:0] v);
    if (v > 44'sh07F_FFFF_FFFF) return 40'sh7F_FFFF_FFFF;
    if (v < -44'sh080_0000_0000) return 40'sh80_0000_0000;
    return v[39:0];
  endfunction

  logic [AddrW-1:0] pidx;
  logic [CountW-1:0] back_idx;
  assign back_idx = fill - 1'b1 - idx;
  assign pidx = back ? back_idx[AddrW-1:0] : idx[AddrW-1:0];

  always_comb begin
    case (state)
      ST_M0:   csel = 3'd0;
      ST_M1:   csel = 3'd1;
      ST_M3:   csel = 3'd3;
      ST_M2:   csel = 3'd2;
      ST_M4:   csel = 3'd4;
      default: csel = 3'd0;
    endcase
  end
  // section input comes straight from the store read in ST_M0
  assign mul_a = (state == ST_M3 || state == ST_M4) ? y :
                 (state == ST_M0) ? rd_data : x;
  // product floored by 2^22 is taken from prod next cycle
  logic signed [41:0] pterm;
  assign pterm = prod[63:22];

  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = fill[AddrW-1:0];
    wdata = 32'(sample_in) <<< 5;
    raddr = pidx;
    case (state)
      ST_LOAD: if (in_acc) begin
        we = 1'b1;
        if (last_in || fill == CountW'(BlockDepth - 1)) state_next = ST_RDX;
      end
      ST_RDX: state_next = ST_M0;
      ST_M0:  state_next = ST_T;
      ST_T:   state_next = ST_M1;
      ST_M1:  state_next = ST_M3;
      ST_M3:  state_next = ST_M2;
      ST_M2:  state_next = ST_M4;
      ST_M4:  state_next = ST_WB;
      ST_WB: begin
        we = 1'b1; waddr = pidx; wdata = y;
        if (idx == fill - 1'b1 && sect == SectW'(Sections - 1) && back) begin
          state_next = ST_OUT_RD;
        end else begin
          state_next = ST_RDX;
        end
      end
      ST_OUT_RD: begin raddr = idx[AddrW-1:0]; state_next = ST_OUT; end
      ST_OUT: begin
        // keep reading the offered entry so a stalled result holds
        raddr = idx[AddrW-1:0];
        if (out_acc) begin
          if (idx == fill - 1'b1) state_next = ST_LOAD;
          else state_next = ST_OUT_RD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  logic pass_end;
  assign pass_end = (idx == fill - 1'b1) && (sect == SectW'(Sections - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD; fill <= '0; idx <= '0; sect <= '0; back <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: if (in_acc) begin
          fill <= fill + 1'b1;
          idx <= '0; sect <= '0; back <= 1'b0;
          for (int i = 0; i < 2*Sections; i++) dly[i] <= '0;
        end
        ST_WB: begin
          if (idx == fill - 1'b1) begin
            idx <= '0;
            if (sect == SectW'(Sections - 1)) begin
              sect <= '0; back <= 1'b1;
              for (int i = 0; i < 2*Sections; i++) dly[i] <= '0;
            end else sect <= sect + 1'b1;
          end else idx <= idx + 1'b1;
        end
        ST_OUT: if (out_acc) begin
          if (idx == fill - 1'b1) begin idx <= '0; fill <= '0; end
          else idx <= idx + 1'b1;
        end
        default: ;
      endcase
      // n1 is a wide accumulator: b1x + s1 - a1y, then b2x - a2y; saturated on store
      case (state)
        ST_M3: n1 <= 44'(pterm) + 44'(dly[{sect, 1'b1}]);
        ST_M2: n1 <= n1 - 44'(pterm);
        ST_M4: begin
          dly[{sect, 1'b0}] <= sat40(n1);
          n1 <= 44'(pterm);
        end
        ST_WB: if (!pass_end) dly[{sect, 1'b1}] <= sat40(n1 - 44'(pterm));
        default: ;
      endcase
    end
  end

  // datapath registers
  logic signed [43:0] tr;
  assign tr = (44'(t) + 44'sd128) >>> 8;
  always_ff @(posedge clk) begin
    if (state == ST_M0) x <= rd_data;
    prod <= 64'(mul_a) * 64'(coef(3'(sect), csel));
    if (state == ST_T) t <= sat40(44'(pterm) + 44'(dly[{sect, 1'b0}]));
    if (state == ST_M1) begin
      if (tr > 44'sh7FFF_FFFF) y <= 32'sh7FFF_FFFF;
      else if (tr < -44'sh8000_0000) y <= 32'sh8000_0000;
      else y <= tr[31:0];
    end
  end

  logic [CountW-1:0] ob;
  logic signed [31:0] ov;
  assign ob = idx;
  assign ov = (rd_data + 32'sd16) >>> 5;
  assign out_valid = (state == ST_OUT);
  assign sample_out = (ov > 32'sd32767) ? 16'sh7FFF :
                      (ov < -32'sd32768) ? 16'sh8000 : ov[15:0];
  assign last_out = (ob == fill - 1'b1);
endmodule

// File: design/zpbc_checker.sv
// Port-level checker for the zero-phase biquad cascade, bound to the top level.
// Depends on zero_phase_biquad_cascade_assert.svh.
`timescale 1ns / 1ps
`include "zero_phase_biquad_cascade_assert.svh"
module zpbc_checker (
  input logic clk, input logic rst,
  input logic in_valid, input logic in_stall,
  input logic out_valid, input logic out_stall,
  input logic [15:0] sample_out, input logic last_out
);
  `ZPBC_ASSERT(no_overlap, !(out_valid && !in_stall), "input open while emitting")
  `ZPBC_NEXT(out_hold, out_valid && out_stall, out_valid && $stable(sample_out), "stalled result changed")
  `ZPBC_NEXT(last_ends, out_valid && !out_stall && last_out, !out_valid, "result after last")
endmodule

bind zero_phase_biquad_cascade zpbc_checker u_chk (.*);
